/* hdl/vector_distance_metric_core_assert.svh */
// Assertion macros used by the core file.
`ifndef VECTOR_DISTANCE_METRIC_CORE_ASSERT_SVH
`define VECTOR_DISTANCE_METRIC_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define VDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdm assertion failed");

// Next-cycle implication, disabled while reset is active.
`define VDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdm assertion failed");

`endif

/* hdl/vdm_pkg.sv */
package vdm_pkg;

  localparam int ElemW      = 16;
  localparam int FieldLanes = 4;
  localparam int LaneCntW   = 3;
  localparam int TermW      = 34;
  localparam int SumW       = 36;
  localparam int AccW       = 44;
  localparam int MetricW    = 2;
  localparam int DefLanes   = 4;
  localparam int QueueDepth = 4;
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic signed [AccW-1:0] OneQ30 = AccW'(1) << 30;

  typedef enum logic [MetricW-1:0] {
    MetricCos    = 2'd0,
    MetricL2     = 2'd1,
    MetricNegDot = 2'd2
  } metric_e;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic                   last_elem;
    logic                   final_cand;
  } vdm_entry_t;

  // Clamp a value one bit wider than the accumulator to the signed 44-bit range.
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
    logic signed [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/vdm_front.sv */
module vdm_front #(
  parameter int LANES = vdm_pkg::DefLanes
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [vdm_pkg::MetricW-1:0]            metric_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [vdm_pkg::ElemW-1:0]       query_i [vdm_pkg::FieldLanes],
  input  logic signed [vdm_pkg::ElemW-1:0]       cand_i  [vdm_pkg::FieldLanes],
  input  logic [vdm_pkg::LaneCntW-1:0]           lanes_valid_i,
  input  logic                                   last_elem_i,
  input  logic                                   final_candidate_i,
  input  logic [vdm_pkg::QCntW-1:0]              queue_cnt_i,
  output logic                                   push_o,
  output vdm_pkg::vdm_entry_t                    entry_o
);
  import vdm_pkg::*;

  localparam int NumLanes = (LANES < FieldLanes) ? LANES : FieldLanes;

  logic                   accept;
  logic                   is_l2;
  logic [LaneCntW-1:0]    lanes_eff;
  logic [QCntW:0]         occupancy;
  logic signed [TermW-1:0] term     [NumLanes];
  logic signed [TermW-1:0] term_q   [NumLanes];
  logic                   a_valid_q, a_last_q, a_final_q;
  logic signed [SumW-1:0] sum_d;
  logic                   b_valid_q;
  vdm_entry_t             b_entry_q;

  // Credits: every item in the two stages already owns a queue slot.
  assign occupancy  = (QCntW+1)'(queue_cnt_i) + (QCntW+1)'(a_valid_q)
                    + (QCntW+1)'(b_valid_q);
  assign in_stall_o = occupancy >= (QCntW+1)'(QueueDepth);
  assign accept     = in_valid_i && !in_stall_o;

  assign is_l2     = (metric_i == MetricL2);
  assign lanes_eff = (lanes_valid_i > LaneCntW'(NumLanes)) ? LaneCntW'(NumLanes)
                                                           : lanes_valid_i;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    logic signed [ElemW:0]   diff;
    logic signed [TermW-1:0] dx, qx, cx;
    assign diff = {query_i[g][ElemW-1], query_i[g]} - {cand_i[g][ElemW-1], cand_i[g]};
    assign dx   = TermW'(diff);
    assign qx   = TermW'(query_i[g]);
    assign cx   = TermW'(cand_i[g]);
    always_comb begin
      if (LaneCntW'(g) >= lanes_eff) begin
        term[g] = '0;
      end else if (is_l2) begin
        term[g] = dx * dx;
      end else begin
        term[g] = qx * cx;
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NumLanes; i++) begin
      sum_d = sum_d + SumW'(term_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      term_q    <= term;
      a_last_q  <= last_elem_i;
      a_final_q <= final_candidate_i;
    end
    if (a_valid_q) begin
      b_entry_q.sum        <= sum_d;
      b_entry_q.last_elem  <= a_last_q;
      b_entry_q.final_cand <= a_final_q;
    end
  end

  assign push_o  = b_valid_q;
  assign entry_o = b_entry_q;

endmodule

/* hdl/vdm_queue.sv */
module vdm_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  vdm_pkg::vdm_entry_t       entry_i,
  input  logic                      pop_i,
  output vdm_pkg::vdm_entry_t       head_o,
  output logic                      empty_o,
  output logic                      full_o,
  output logic [vdm_pkg::QCntW-1:0] cnt_o
);
  import vdm_pkg::*;

  vdm_entry_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign cnt_o   = cnt_q;

endmodule

/* hdl/vdm_back.sv */
module vdm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [vdm_pkg::MetricW-1:0]     metric_i,
  input  vdm_pkg::vdm_entry_t             head_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [vdm_pkg::AccW-1:0] distance_o,
  output logic                            batch_done_o
);
  import vdm_pkg::*;

  logic signed [AccW-1:0] acc_q, acc_d, acc_new, dist_d, dist_q;
  logic                   out_valid_q, done_q, out_free;

  assign acc_new = sat_acc((AccW+1)'(acc_q) + (AccW+1)'(head_i.sum));

  always_comb begin
    case (metric_i)
      MetricL2:     dist_d = acc_new;
      MetricNegDot: dist_d = sat_acc((AccW+1)'(0) - (AccW+1)'(acc_new));
      default:      dist_d = sat_acc((AccW+1)'(OneQ30) - (AccW+1)'(acc_new));
    endcase
  end

  // Hold a closing transaction in the queue until the result register frees up.
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && (!head_i.last_elem || out_free);

  always_comb begin
    acc_d = acc_q;
    if (pop_o) begin
      acc_d = head_i.last_elem ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (pop_o && head_i.last_elem) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last_elem) begin
      dist_q <= dist_d;
      done_q <= head_i.final_cand;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = dist_q;
  assign batch_done_o = done_q;

endmodule

/* hdl/vector_distance_metric_core.sv */
// Channel   Direction  Handshake                  Carries
// input     in         in_valid_i / in_stall_o    four element pairs, lane count, flags
// result    out        out_valid_o / out_stall_i  distance_o, batch_done_o
// config    in         cfg_valid_i / cfg_ready_o  metric code (cfg_data_i)
//
// One item is taken per cycle while in_stall_o is low, through the front pipeline:
// lane products, then lane sum, then queue; the result register raises out_valid_o.
// The back accumulates one queued item per cycle while the queue is not empty, holds
// a closing item while a result waits; in_stall_o rises at four items staged or queued.
// Reset clears the accumulator, the metric (cosine) and all valid state.
`include "vector_distance_metric_core_assert.svh"

module vector_distance_metric_core #(
  parameter int LANES = vdm_pkg::DefLanes
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vdm_pkg::MetricW-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [vdm_pkg::ElemW-1:0] query_elem0_i,
  input  logic signed [vdm_pkg::ElemW-1:0] query_elem1_i,
  input  logic signed [vdm_pkg::ElemW-1:0] query_elem2_i,
  input  logic signed [vdm_pkg::ElemW-1:0] query_elem3_i,
  input  logic signed [vdm_pkg::ElemW-1:0] cand_elem0_i,
  input  logic signed [vdm_pkg::ElemW-1:0] cand_elem1_i,
  input  logic signed [vdm_pkg::ElemW-1:0] cand_elem2_i,
  input  logic signed [vdm_pkg::ElemW-1:0] cand_elem3_i,
  input  logic [vdm_pkg::LaneCntW-1:0]     lanes_valid_i,
  input  logic                             last_elem_i,
  input  logic                             final_candidate_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [vdm_pkg::AccW-1:0]  distance_o,
  output logic                             batch_done_o
);
  import vdm_pkg::*;

  logic [MetricW-1:0]      metric_q;
  logic signed [ElemW-1:0] query [FieldLanes];
  logic signed [ElemW-1:0] cand  [FieldLanes];
  logic                    push, pop, q_empty, q_full;
  logic [QCntW-1:0]        q_cnt;
  vdm_entry_t              push_entry, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MetricCos;
    end else if (cfg_valid_i && cfg_ready_o) begin
      metric_q <= cfg_data_i;
    end
  end

  assign query[0] = query_elem0_i;
  assign query[1] = query_elem1_i;
  assign query[2] = query_elem2_i;
  assign query[3] = query_elem3_i;
  assign cand[0]  = cand_elem0_i;
  assign cand[1]  = cand_elem1_i;
  assign cand[2]  = cand_elem2_i;
  assign cand[3]  = cand_elem3_i;

  vdm_front #(
    .LANES(LANES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .metric_i         (metric_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .query_i          (query),
    .cand_i           (cand),
    .lanes_valid_i    (lanes_valid_i),
    .last_elem_i      (last_elem_i),
    .final_candidate_i(final_candidate_i),
    .queue_cnt_i      (q_cnt),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  vdm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .full_o (q_full),
    .cnt_o  (q_cnt)
  );

  vdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .metric_i    (metric_q),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o),
    .batch_done_o(batch_done_o)
  );

  `VDM_ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, push, !q_full || pop)
  `VDM_ASSERT_IMPLY(a_no_underflow, clk_i, rst_ni, pop, !q_empty)
  `VDM_ASSERT_IMPLY(a_result_slot_free, clk_i, rst_ni, pop && head.last_elem,
                    !out_valid_o || !out_stall_i)
  `VDM_ASSERT_NEXT(a_result_follows_close, clk_i, rst_ni, pop && head.last_elem,
                   out_valid_o)

endmodule
